/* design/ascii_coordinate_line_parser_assert.svh */
// Assertion macros shared by the parser RTL.
`ifndef ASCII_COORDINATE_LINE_PARSER_ASSERT_SVH
`define ASCII_COORDINATE_LINE_PARSER_ASSERT_SVH

// Same-cycle implication.
`define ACL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ACL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/acl_pkg.sv */
package acl_pkg;

   localparam int LEN_W   = 7;
   localparam int KEPT_W  = 5;
   localparam int PHASE_W = 3;
   localparam int COORD_W = 16;
   localparam int BYTE_W  = 8;
   localparam int STAT_W  = 2;

   localparam int MAX_LINE_BYTES_DEF = 64;
   localparam int MAX_KEPT_CHARS_DEF = 31;

   localparam logic [LEN_W-1:0] LEN_SAT = {LEN_W{1'b1}};

   localparam logic [BYTE_W-1:0] CHAR_NL    = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CHAR_COMMA = 8'h2C;
   localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

   // parse phases
   localparam logic [PHASE_W-1:0] PH_SEEK   = 3'd0;
   localparam logic [PHASE_W-1:0] PH_XDIG   = 3'd1;
   localparam logic [PHASE_W-1:0] PH_YSTART = 3'd2;
   localparam logic [PHASE_W-1:0] PH_YSIGN  = 3'd3;
   localparam logic [PHASE_W-1:0] PH_YDIG   = 3'd4;
   localparam logic [PHASE_W-1:0] PH_DONE   = 3'd5;
   localparam logic [PHASE_W-1:0] PH_FAIL   = 3'd6;

   // line status codes
   localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
   localparam logic [STAT_W-1:0] ST_FAIL    = 2'd1;
   localparam logic [STAT_W-1:0] ST_TOOLONG = 2'd2;

   typedef logic [COORD_W-1:0] coord_type;

   // acc * 10 + digit, wrapped to the accumulator width
   function automatic coord_type acc_digit(input coord_type acc,
                                           input logic [BYTE_W-1:0] c);
      logic [BYTE_W-1:0] d;
      d = c - CHAR_ZERO;
      return (acc << 3) + (acc << 1) + coord_type'(d[3:0]);
   endfunction

endpackage

/* design/acl_if.sv */
interface acl_req_if import acl_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface acl_rsp_if import acl_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [STAT_W-1:0]         line_status;
   logic signed [COORD_W-1:0] x_coord;
   logic signed [COORD_W-1:0] y_coord;

   modport source (output valid, output line_status, output x_coord, output y_coord,
                   input ready);
   modport sink   (input valid, input line_status, input x_coord, input y_coord,
                   output ready);
endinterface

/* design/ascii_coordinate_line_parser.sv */
// A newline word is judged and loaded into the result register by its accepting edge.
// Throughput: one byte word per cycle; the parse state and the x10 accumulate
// update in a single pass between the state registers and the result register.
// Input stalls only while a result word is held and the sink is not ready.
// Reset (synchronous, active high) clears parse state and the result valid.
`include "ascii_coordinate_line_parser_assert.svh"

module ascii_coordinate_line_parser import acl_pkg::*; #(
   parameter int MAX_LINE_BYTES = MAX_LINE_BYTES_DEF,
   parameter int MAX_KEPT_CHARS = MAX_KEPT_CHARS_DEF
) (
   input logic        clock,
   input logic        reset,
   acl_req_if.sink    req,
   acl_rsp_if.source  rsp
);

   // ---- parse state -------------------------------------------------------
   logic [PHASE_W-1:0] phase_ff,   phase_in;
   logic [LEN_W-1:0]   len_ff,     len_in;
   logic [KEPT_W-1:0]  kept_ff,    kept_in;
   logic               stopped_ff, stopped_in;
   coord_type          xacc_ff,    xacc_in;
   coord_type          yacc_ff,    yacc_in;
   logic               yneg_ff,    yneg_in;

   // ---- result register ---------------------------------------------------
   logic               rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]  status_ff,    status_in;
   coord_type          xout_ff,      xout_in;
   coord_type          yout_ff,      yout_in;

   logic [BYTE_W-1:0]  c;
   logic               accept;
   logic               is_nl, is_digit, is_keepable;

   assign c           = req.rx_byte;
   assign req.ready   = !rsp_valid_ff || rsp.ready;   // result reg free or read
   assign accept      = req.valid && req.ready;
   assign is_nl       = (c == CHAR_NL);
   assign is_digit    = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   assign is_keepable = is_digit || (c == CHAR_COMMA) || (c == CHAR_MINUS);

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.line_status = status_ff;
   assign rsp.x_coord     = xout_ff;
   assign rsp.y_coord     = yout_ff;

   always_comb begin
      phase_in     = phase_ff;
      len_in       = len_ff;
      kept_in      = kept_ff;
      stopped_in   = stopped_ff;
      xacc_in      = xacc_ff;
      yacc_in      = yacc_ff;
      yneg_in      = yneg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      status_in    = status_ff;
      xout_in      = xout_ff;
      yout_in      = yout_ff;

      if (accept) begin
         if (is_nl) begin
            // end of line: judge it, emit one result word, start afresh
            rsp_valid_in = 1'b1;
            xout_in      = '0;
            yout_in      = '0;
            if (len_ff >= LEN_W'(MAX_LINE_BYTES)) begin
               status_in = ST_TOOLONG;
            end else if (phase_ff == PH_YDIG || phase_ff == PH_DONE) begin
               status_in = ST_OK;
               xout_in   = xacc_ff;
               yout_in   = yneg_ff ? coord_type'(-yacc_ff) : yacc_ff;
            end else begin
               status_in = ST_FAIL;
            end
            phase_in   = PH_SEEK;
            len_in     = '0;
            kept_in    = '0;
            stopped_in = 1'b0;
            xacc_in    = '0;
            yacc_in    = '0;
            yneg_in    = 1'b0;
         end else begin
            if (len_ff != LEN_SAT) begin
               len_in = len_ff + 1'b1;
            end
            if (phase_ff == PH_SEEK) begin
               // everything before the first digit is skipped, CR included
               if (is_digit) begin
                  phase_in = PH_XDIG;
                  xacc_in  = acc_digit('0, c);
                  kept_in  = KEPT_W'(1);
               end
            end else if (!stopped_ff && (kept_ff < KEPT_W'(MAX_KEPT_CHARS))) begin
               if (c == CHAR_CR) begin
                  stopped_in = 1'b1;
               end else if (is_keepable) begin
                  kept_in = kept_ff + 1'b1;
                  case (phase_ff)
                     PH_XDIG: begin
                        if (is_digit) begin
                           xacc_in = acc_digit(xacc_ff, c);
                        end else if (c == CHAR_COMMA) begin
                           phase_in = PH_YSTART;
                        end else begin
                           phase_in = PH_FAIL;
                        end
                     end
                     PH_YSTART: begin
                        if (is_digit) begin
                           yacc_in  = acc_digit(yacc_ff, c);
                           phase_in = PH_YDIG;
                        end else if (c == CHAR_MINUS) begin
                           yneg_in  = 1'b1;
                           phase_in = PH_YSIGN;
                        end else begin
                           phase_in = PH_FAIL;
                        end
                     end
                     PH_YSIGN: begin
                        if (is_digit) begin
                           yacc_in  = acc_digit(yacc_ff, c);
                           phase_in = PH_YDIG;
                        end else begin
                           phase_in = PH_FAIL;
                        end
                     end
                     PH_YDIG: begin
                        if (is_digit) begin
                           yacc_in = acc_digit(yacc_ff, c);
                        end else begin
                           phase_in = PH_DONE;   // trailing kept text ignored
                        end
                     end
                     default: begin
                        // done or failed: nothing more to learn from this line
                     end
                  endcase
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SEEK;
         len_ff       <= '0;
         kept_ff      <= '0;
         stopped_ff   <= 1'b0;
         xacc_ff      <= '0;
         yacc_ff      <= '0;
         yneg_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         len_ff       <= len_in;
         kept_ff      <= kept_in;
         stopped_ff   <= stopped_in;
         xacc_ff      <= xacc_in;
         yacc_ff      <= yacc_in;
         yneg_ff      <= yneg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload needs no reset
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      xout_ff   <= xout_in;
      yout_ff   <= yout_in;
   end

   // ---- checks ------------------------------------------------------------
   `ACL_ASSERT_NEXT(a_nl_gives_word, clock, reset, accept && is_nl, rsp_valid_ff, "newline gave no result word")
   `ACL_ASSERT_NEXT(a_nl_clears, clock, reset, accept && is_nl, phase_ff == PH_SEEK && len_ff == '0 && kept_ff == '0, "line state not cleared after newline")
   `ACL_ASSERT_NOW(a_fail_zero, clock, reset, rsp_valid_ff && status_ff != ST_OK, xout_ff == '0 && yout_ff == '0, "coordinates not zero on failed line")
   `ACL_ASSERT_NOW(a_kept_bound, clock, reset, 1'b1, kept_ff <= KEPT_W'(MAX_KEPT_CHARS), "kept count beyond limit")

endmodule
